// ----- hw/rtl/time_window_filter_stable_sorter_defines.svh -----
// assertion macros for the time window filter and sorter
// used by the port checker; needs clk_i and rst_ni in scope
`ifndef TIME_WINDOW_FILTER_STABLE_SORTER_DEFINES_SVH
`define TIME_WINDOW_FILTER_STABLE_SORTER_DEFINES_SVH

// checked property, masked while reset is asserted
`define TWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked property, active during reset as well
`define TWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/tws_pkg.sv -----
// shared types and codes for the time window filter and sorter
// no dependencies
package tws_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FILTERED = 3'd1,
    ST_FULL     = 3'd2,
    ST_OUT      = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_START_LIMIT    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_LIMIT_ON = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_LIMIT      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_LIMIT_ON   = 3'd3;

endpackage

// ----- hw/rtl/tws_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module tws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tws_window.sv -----
// window limit registers and the drop decision for a loaded record
// depends on tws_pkg
module tws_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                  cfg_data_i,
  input  logic signed [63:0]           rec_start_i,
  input  logic signed [63:0]           rec_end_i,
  output logic                         drop_o
);

  logic signed [63:0] start_limit_q;
  logic               start_limit_on_q;
  logic signed [63:0] end_limit_q;
  logic               end_limit_on_q;
  logic               early_drop;
  logic               late_drop;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_limit_q    <= '0;
      start_limit_on_q <= 1'b0;
      end_limit_q      <= '0;
      end_limit_on_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tws_pkg::CFG_START_LIMIT:    start_limit_q    <= cfg_data_i;
        tws_pkg::CFG_START_LIMIT_ON: start_limit_on_q <= cfg_data_i[0];
        tws_pkg::CFG_END_LIMIT:      end_limit_q      <= cfg_data_i;
        tws_pkg::CFG_END_LIMIT_ON:   end_limit_on_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // record wholly before the start or wholly after the end
  assign early_drop = start_limit_on_q && (rec_start_i < start_limit_q)
                      && (rec_end_i < start_limit_q);
  assign late_drop  = end_limit_on_q && (rec_start_i > end_limit_q)
                      && (rec_end_i > end_limit_q);
  assign drop_o     = early_drop || late_drop;

endmodule

// ----- hw/rtl/time_window_filter_stable_sorter.sv -----
// top level: record store, in-place stable insertion sort, read out
// depends on tws_pkg, tws_ram, tws_window
//
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o func, rec_start, rec_end, rec_tag
// out      output     out_valid_o/out_stall_i status, out_start, out_end, out_tag,
//                                             out_last
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index, cfg_data
//
// load, clear and a read of an empty store answer in the cycle after the
// request is taken; a read of a record first passes the registered ram read.
// the first read after a load sorts the store in place, one record and one
// position move at a time through the single ram.
// reset clears counters and window registers; the store needs no clearing.
// a stalled result blocks new requests until it is taken.
module time_window_filter_stable_sorter #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic signed [63:0]          rec_start_i,
  input  logic signed [63:0]          rec_end_i,
  input  logic [31:0]                 rec_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic signed [63:0]          out_start_o,
  output logic signed [63:0]          out_end_o,
  output logic [31:0]                 out_tag_o,
  output logic                        out_last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tws_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned TW = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int unsigned DW = 128 + TW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_LAT,
    S_SHIFT,
    S_PLACE,
    S_OUT_RD,
    S_OUT_WAIT
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic              sorted_q, sorted_d;
  logic [AW-1:0]     i_q, i_d;
  logic [AW-1:0]     j_q, j_d;
  logic [DW-1:0]     key_q, key_d;

  logic              out_valid_q;
  tws_pkg::status_e  status_q;
  logic [63:0]       out_start_q;
  logic [63:0]       out_end_q;
  logic [TW-1:0]     out_tag_q;
  logic              out_last_q;

  logic              out_set;
  tws_pkg::status_e  set_status;
  logic              set_rec;
  logic              set_last;
  logic              read_step;
  logic              accept;
  logic              drop;
  logic              next_done;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DW-1:0]     ram_rdata;
  logic signed [63:0] rd_end;
  logic signed [63:0] key_end;

  assign cfg_ready_o = 1'b1;

  tws_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rec_start_i (rec_start_i),
    .rec_end_i   (rec_end_i),
    .drop_o      (drop)
  );

  tws_ram #(
    .Width (DW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // take a request only when idle and the result slot is free or freeing
  assign in_stall_o = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;

  assign rd_end    = ram_rdata[TW +: 64];
  assign key_end   = key_q[TW +: 64];
  assign next_done = (({1'b0, i_q} + CW'(1)) == count_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    sorted_d   = sorted_q;
    i_d        = i_q;
    j_d        = j_q;
    key_d      = key_q;
    out_set    = 1'b0;
    set_status = tws_pkg::ST_EMPTY;
    set_rec    = 1'b0;
    set_last   = 1'b0;
    read_step  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (tws_pkg::func_e'(func_i))
            tws_pkg::FUNC_LOAD: begin
              out_set = 1'b1;
              if (drop) begin
                set_status = tws_pkg::ST_FILTERED;
              end else if (count_q == CW'(CAPACITY)) begin
                set_status = tws_pkg::ST_FULL;
              end else begin
                set_status = tws_pkg::ST_STORED;
                ram_we     = 1'b1;
                ram_waddr  = count_q[AW-1:0];
                ram_wdata  = {rec_start_i, rec_end_i, rec_tag_i[TW-1:0]};
                count_d    = count_q + CW'(1);
                sorted_d   = 1'b0;
              end
            end
            tws_pkg::FUNC_READ: begin
              if (!sorted_q && (count_q > CW'(1))) begin
                i_d     = AW'(1);
                state_d = S_KEY_RD;
              end else begin
                sorted_d  = 1'b1;
                read_step = 1'b1;
              end
            end
            tws_pkg::FUNC_CLEAR: begin
              out_set  = 1'b1;
              count_d  = '0;
              pos_d    = '0;
              sorted_d = 1'b0;
            end
            default: begin
              out_set = 1'b1;
            end
          endcase
        end
      end
      S_KEY_RD: begin
        ram_raddr = i_q;
        state_d   = S_KEY_LAT;
      end
      S_KEY_LAT: begin
        key_d     = ram_rdata;
        j_d       = i_q;
        ram_raddr = i_q - AW'(1);
        state_d   = S_SHIFT;
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        if (key_end < rd_end) begin
          // move the larger record up one place
          ram_wdata = ram_rdata;
          if (j_q == AW'(1)) begin
            j_d     = '0;
            state_d = S_PLACE;
          end else begin
            j_d       = j_q - AW'(1);
            ram_raddr = j_q - AW'(2);
          end
        end else begin
          ram_wdata = key_q;
          if (next_done) begin
            sorted_d = 1'b1;
            state_d  = S_OUT_RD;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_KEY_RD;
          end
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
        if (next_done) begin
          sorted_d = 1'b1;
          state_d  = S_OUT_RD;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_KEY_RD;
        end
      end
      S_OUT_RD: begin
        state_d   = S_IDLE;
        read_step = 1'b1;
      end
      S_OUT_WAIT: begin
        out_set    = 1'b1;
        set_status = tws_pkg::ST_OUT;
        set_rec    = 1'b1;
        set_last   = ((pos_q + CW'(1)) == count_q);
        pos_d      = pos_q + CW'(1);
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // fetch the record at the read position, or report nothing left
    if (read_step) begin
      if (pos_q >= count_q) begin
        out_set    = 1'b1;
        set_status = tws_pkg::ST_EMPTY;
        state_d    = S_IDLE;
      end else begin
        ram_raddr = pos_q[AW-1:0];
        state_d   = S_OUT_WAIT;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      sorted_q    <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      sorted_q <= sorted_d;
      i_q      <= i_d;
      j_q      <= j_d;
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (out_set) begin
      status_q    <= set_status;
      out_last_q  <= set_last;
      out_start_q <= set_rec ? ram_rdata[DW-1 -: 64] : 64'd0;
      out_end_q   <= set_rec ? ram_rdata[TW +: 64] : 64'd0;
      out_tag_q   <= set_rec ? ram_rdata[TW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_start_o = out_start_q;
  assign out_end_o   = out_end_q;
  assign out_tag_o   = 32'(out_tag_q);
  assign out_last_o  = out_last_q;

endmodule

// ----- hw/rtl/tws_checker.sv -----
// port level checks for the time window filter and sorter, bound to the top
// depends on tws_pkg and the assertion macro header
`include "time_window_filter_stable_sorter_defines.svh"

module tws_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [2:0]                  status_o,
  input logic [63:0]                 out_start_o,
  input logic [63:0]                 out_end_o,
  input logic [31:0]                 out_tag_o,
  input logic                        out_last_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o
);

  // a stalled result keeps its status
  `TWS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o), "stalled result changed")

  // only a returned record carries data
  `TWS_ASSERT(a_no_data, out_valid_o && (status_o != tws_pkg::ST_OUT) |-> (out_start_o == 64'd0) && (out_end_o == 64'd0) && (out_tag_o == 32'd0) && !out_last_o, "data on a result without a record")

  // no request taken while a result is stuck
  `TWS_ASSERT(a_stall_back, out_valid_o && out_stall_i |-> in_stall_o, "request taken while result stalled")

  // configuration is always taken
  `TWS_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration port not ready")

endmodule

bind time_window_filter_stable_sorter tws_checker u_tws_checker (.*);

// ----- sim/time_window_filter_stable_sorter_test.sv -----
// self-checking testbench for the time window filter and stable sorter
// depends on tws_pkg and the time_window_filter_stable_sorter rtl
`timescale 1ns / 1ps

module time_window_filter_stable_sorter_test;

  localparam int unsigned Depth      = 1024;
  localparam int unsigned CycleLimit = 3000000;
  localparam logic signed [63:0] SMin = 64'sh8000000000000000;
  localparam logic signed [63:0] SMax = 64'sh7fffffffffffffff;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] rstart;
    logic signed [63:0] rend;
    logic [31:0]        tag;
    logic               last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = tws_pkg::FUNC_NONE;
  logic signed [63:0] rec_start_i = '0;
  logic signed [63:0] rec_end_i = '0;
  logic [31:0] rec_tag_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic signed [63:0] out_start_o;
  logic signed [63:0] out_end_o;
  logic [31:0] out_tag_o;
  logic out_last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tws_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  // shadow of the block state
  logic signed [63:0] win_start;
  logic               win_start_on;
  logic signed [63:0] win_end;
  logic               win_end_on;
  logic signed [63:0] start_mem [Depth];
  logic signed [63:0] end_mem [Depth];
  logic [31:0]        tag_mem [Depth];
  int unsigned        rec_count;
  int unsigned        rd_pos;
  bit                 in_order;

  answer_t answer_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  int unsigned stall_left = 0;

  time_window_filter_stable_sorter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .rec_start_i, .rec_end_i,
    .rec_tag_i, .out_valid_o, .out_stall_i, .status_o, .out_start_o, .out_end_o,
    .out_tag_o, .out_last_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stable insertion sort of the shadow store by end time
  task automatic order_store();
    logic signed [63:0] ks, ke;
    logic [31:0] kt;
    int unsigned j;
    for (int unsigned i = 1; i < rec_count; i++) begin
      ks = start_mem[i];
      ke = end_mem[i];
      kt = tag_mem[i];
      j = i;
      while (j > 0 && ke < end_mem[j-1]) begin
        start_mem[j] = start_mem[j-1];
        end_mem[j] = end_mem[j-1];
        tag_mem[j] = tag_mem[j-1];
        j--;
      end
      start_mem[j] = ks;
      end_mem[j] = ke;
      tag_mem[j] = kt;
    end
  endtask

  // expected result of one accepted request
  task automatic predict_answer(logic [1:0] f, logic signed [63:0] s,
                                logic signed [63:0] e, logic [31:0] t);
    answer_t a;
    bit drop;
    a = '0;
    a.status = tws_pkg::ST_EMPTY;
    case (f)
      tws_pkg::FUNC_LOAD: begin
        drop = (win_start_on && s < win_start && e < win_start) ||
               (win_end_on && e > win_end && s > win_end);
        if (drop) begin
          a.status = tws_pkg::ST_FILTERED;
        end else if (rec_count >= Depth) begin
          a.status = tws_pkg::ST_FULL;
        end else begin
          start_mem[rec_count] = s;
          end_mem[rec_count] = e;
          tag_mem[rec_count] = t;
          rec_count++;
          in_order = 1'b0;
          a.status = tws_pkg::ST_STORED;
        end
      end
      tws_pkg::FUNC_READ: begin
        if (!in_order) begin
          order_store();
          in_order = 1'b1;
        end
        if (rd_pos < rec_count) begin
          a.status = tws_pkg::ST_OUT;
          a.rstart = start_mem[rd_pos];
          a.rend = end_mem[rd_pos];
          a.tag = tag_mem[rd_pos];
          a.last = (rd_pos + 1 == rec_count);
          rd_pos++;
        end
      end
      tws_pkg::FUNC_CLEAR: begin
        rec_count = 0;
        rd_pos = 0;
        in_order = 1'b0;
      end
      default: ;
    endcase
    answer_q.push_back(a);
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, out_start_o, out_end_o, out_tag_o, out_last_o};
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = answer_q.pop_front();
        if (got.status !== want.status || got.rstart !== want.rstart ||
            got.rend !== want.rend || got.tag !== want.tag || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st %0d s %0d e %0d tag %h last %0d, got st %0d s %0d e %0d tag %h last %0d",
                     want.status, want.rstart, want.rend, want.tag, want.last,
                     got.status, got.rstart, got.rend, got.tag, got.last);
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 9);
    end else if (stall_left > 0 && out_valid_o) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  // one request on the input channel
  task automatic send_req(logic [1:0] f, logic signed [63:0] s,
                          logic signed [63:0] e, logic [31:0] t);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    rec_start_i <= s;
    rec_end_i <= e;
    rec_tag_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_answer(f, s, e, t);
  endtask

  task automatic load_rec(logic signed [63:0] s, logic signed [63:0] e, logic [31:0] t);
    send_req(tws_pkg::FUNC_LOAD, s, e, t);
  endtask

  task automatic read_n(int unsigned n);
    repeat (n) send_req(tws_pkg::FUNC_READ, $urandom, $urandom, $urandom);
  endtask

  // wait until every result is back and the block is quiet
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only while idle; the caller drops valid after the last one
  task automatic write_cfg(logic [tws_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      tws_pkg::CFG_START_LIMIT:    win_start = value;
      tws_pkg::CFG_START_LIMIT_ON: win_start_on = value[0];
      tws_pkg::CFG_END_LIMIT:      win_end = value;
      tws_pkg::CFG_END_LIMIT_ON:   win_end_on = value[0];
      default: ;
    endcase
  endtask

  task automatic set_window(logic signed [63:0] lo, logic lo_on,
                            logic signed [63:0] hi, logic hi_on);
    wait_idle();
    write_cfg(tws_pkg::CFG_START_LIMIT, lo);
    write_cfg(tws_pkg::CFG_START_LIMIT_ON, {63'(lo_on ? 0 : $urandom), lo_on});
    write_cfg(tws_pkg::CFG_END_LIMIT, hi);
    write_cfg(tws_pkg::CFG_END_LIMIT_ON, {63'(hi_on ? 0 : $urandom), hi_on});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random time value, biased toward extremes and collisions
  function automatic logic signed [63:0] pick_time();
    case ($urandom_range(0, 7))
      0: return SMin;
      1: return SMax;
      2: return {$urandom, $urandom};
      3: return 64'(-1);
      default: return 64'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // field extremes, empty reads, unused selector
  task automatic test_extremes();
    send_req(tws_pkg::FUNC_READ, '0, '0, '0);
    load_rec(SMax, SMax, 32'hffffffff);
    load_rec(SMin, SMin, 32'h0);
    load_rec(64'sd0, 64'(-1), 32'h5555aaaa);
    load_rec(SMin, SMax, 32'haaaa5555);
    read_n(5);
    send_req(tws_pkg::FUNC_NONE, SMax, SMin, 32'hffffffff);
    send_req(tws_pkg::FUNC_CLEAR, SMax, SMax, 32'hffffffff);
    read_n(1);
  endtask

  // window limits, boundaries and order of checks
  task automatic test_window();
    set_window(-64'sd10, 1'b1, 64'sd10, 1'b1);
    load_rec(-64'sd11, -64'sd11, 32'd1);
    load_rec(-64'sd11, -64'sd10, 32'd2);
    load_rec(64'sd11, 64'sd11, 32'd3);
    load_rec(64'sd10, 64'sd11, 32'd4);
    load_rec(-64'sd20, 64'sd20, 32'd5);
    read_n(4);
    send_req(tws_pkg::FUNC_CLEAR, '0, '0, '0);
    set_window(SMax, 1'b1, SMin, 1'b1);
    load_rec(SMax, SMin, 32'd6);
    load_rec(SMax, SMax, 32'd7);
    load_rec(SMin, SMin, 32'd8);
    read_n(2);
    send_req(tws_pkg::FUNC_CLEAR, '0, '0, '0);
  endtask

  // equal keys keep arrival order, load after reads resorts
  task automatic test_stable();
    set_window(SMin, 1'b0, SMax, 1'b0);
    load_rec(64'sd1, 64'sd5, 32'd10);
    load_rec(64'sd2, 64'sd3, 32'd11);
    load_rec(64'sd3, 64'sd5, 32'd12);
    load_rec(64'sd4, 64'sd3, 32'd13);
    read_n(2);
    load_rec(64'sd5, 64'sd1, 32'd14);
    read_n(4);
    send_req(tws_pkg::FUNC_CLEAR, '0, '0, '0);
  endtask

  // fill the store, then full and filtered loads
  task automatic test_full();
    quiet = 1'b1;
    for (int i = 0; i < Depth; i++) load_rec(64'(i), 64'(i), $urandom);
    load_rec(64'sd5, 64'sd5, 32'd1);
    set_window(64'sd100000, 1'b1, SMax, 1'b0);
    load_rec(64'sd0, 64'sd0, 32'd2);
    load_rec(SMax, SMax, 32'd3);
    read_n(3);
    send_req(tws_pkg::FUNC_CLEAR, '0, '0, '0);
    quiet = 1'b0;
  endtask

  // random phases of clear, load, read with noise
  task automatic test_random();
    int unsigned sent, n, r;
    sent = 0;
    while (sent < 60) begin
      if ($urandom_range(0, 3) == 0)
        set_window(pick_time(), $urandom_range(0, 1), pick_time(), $urandom_range(0, 1));
      quiet = ($urandom_range(0, 5) == 0);
      send_req(tws_pkg::FUNC_CLEAR, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_req(tws_pkg::FUNC_NONE, pick_time(), pick_time(), $urandom);
        else if (r < 3) read_n(1);
        else load_rec(pick_time(), pick_time(), $urandom);
      end
      read_n(n + $urandom_range(0, 3));
      sent += 2 * n + 2;
    end
    quiet = 1'b0;
  endtask

  initial begin
    win_start = '0;
    win_start_on = 1'b0;
    win_end = '0;
    win_end_on = 1'b0;
    rec_count = 0;
    rd_pos = 0;
    in_order = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_window();
    test_stable();
    test_full();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_ram.sv
hw/rtl/tws_window.sv
hw/rtl/time_window_filter_stable_sorter.sv
hw/rtl/tws_checker.sv
sim/time_window_filter_stable_sorter_test.sv
